### rtl/additive_lagged_fibonacci_prng_unit_macros.svh
// Assertion macros shared by the lagged Fibonacci generator checker.
`ifndef ADDITIVE_LAGGED_FIBONACCI_PRNG_UNIT_MACROS_SVH
`define ADDITIVE_LAGGED_FIBONACCI_PRNG_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ALF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ALF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/alf_pkg.sv
// Shared constants and types of the lagged Fibonacci generator.
package alf_pkg;

   localparam int LONG_LAG  = 31;
   localparam int SHORT_LAG = 3;
   localparam int ADDR_W    = 5;
   localparam int WORD_W    = 32;
   localparam int MULT_W    = 15;
   localparam int PROD_W    = WORD_W + MULT_W;
   localparam int WARM_FIRST = 34;

   localparam logic [MULT_W-1:0] MULT          = 15'd16807;
   localparam logic [ADDR_W-1:0] LAST_SLOT     = ADDR_W'(LONG_LAG - 1);
   localparam logic [ADDR_W-1:0] WARM_START    = ADDR_W'(WARM_FIRST % LONG_LAG);

   // Control from the reseed sequencer to the ring datapath.
   typedef struct packed {
      logic              busy;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              step;
      logic              wp_load;
   } alf_ctrl_type;

endpackage

### rtl/alf_ram.sv
// Generic RAM with one write port and two registered read ports.
module alf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

### rtl/alf_seq.sv
// Reseed sequencer: fills the ring from the seed and runs the warm-up steps.
module alf_seq #(
   parameter int WARMUP_END = 344
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [alf_pkg::WORD_W-1:0] seed,
   output alf_pkg::alf_ctrl_type      ctrl
);
   import alf_pkg::*;

   localparam int WARM_STEPS = WARMUP_END - WARM_FIRST;
   localparam int CNT_W      = $clog2(WARMUP_END + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SEED = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_FOLD = 3'd3;
   localparam logic [2:0] ST_WARM = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] prev_ff, prev_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0] fold_val;

   // Two-fold sum of base 2^31 digits, kept as is: a nonzero multiple of
   // 2^31-1 folds to 0x7fffffff.
   function automatic logic [WORD_W-1:0] fold31(input logic [PROD_W-1:0] p);
      logic [WORD_W-1:0] m;
      m = WORD_W'(p[PROD_W-1:31]) + {1'b0, p[30:0]};
      if (m[31]) begin
         m = 32'd1 + {1'b0, m[30:0]};
      end
      return m;
   endfunction

   assign fold_val = fold31(prod_ff);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      prev_in  = prev_ff;
      prod_in  = prod_ff;
      ctrl         = '0;
      ctrl.busy    = (state_ff != ST_IDLE);
      ctrl.wr_addr = idx_ff;
      ctrl.wr_data = prev_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               prev_in  = seed;
               idx_in   = '0;
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            ctrl.wr_en = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(prev_ff) * PROD_W'(MULT);
            idx_in   = idx_ff + ADDR_W'(1);
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_data = fold_val;
            prev_in      = fold_val;
            if (idx_ff == LAST_SLOT) begin
               ctrl.wp_load = 1'b1;
               cnt_in       = CNT_W'(WARM_STEPS);
               state_in     = (WARM_STEPS == 0) ? ST_IDLE : ST_WARM;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_WARM: begin
            ctrl.step = 1'b1;
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
      prev_ff <= prev_in;
      prod_ff <= prod_in;
   end

endmodule

### rtl/additive_lagged_fibonacci_prng_unit.sv
// Top level of the additive lagged Fibonacci generator, lags 31 and 3.
// A draw passes the stage-one read register, then the result register behind rsp_tvalid; draws
// sustain one per cycle while rsp_tready is high. A reseed keeps req_tready low while the
// sequencer runs: one seed write, a multiply and a fold per derived word, then one warm-up step per cycle.
// Reset is synchronous: the ring reads as zero through per-word valid bits, no clearing pass.
// The ring is a 31-word RAM with two read ports; a draw reads both lags and writes the sum from stage one.
module additive_lagged_fibonacci_prng_unit #(
   parameter int WARMUP_END = 344
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // seed[31:0]
   input  logic        req_tuser,   // action[0]: 0 reseed, 1 draw
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // value[30:0], zero[31]
);
   import alf_pkg::*;

   alf_ctrl_type      ctrl;
   logic              accept, draw_accept, reseed_accept, issue, out_free, s1_go;
   logic [ADDR_W-1:0] wp_ff, wp_in, back_addr;
   logic [ADDR_W-1:0] s1_slot_ff;
   logic              s1_valid_ff, s1_valid_in, s1_draw_ff;
   logic              va_ff, vb_ff;
   logic [LONG_LAG-1:0] valid_ff, valid_in;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [WORD_W-1:0] ram_wdata, rd_a, rd_b, sum;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [30:0]       rsp_value_ff;

   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign s1_go         = s1_valid_ff && (!s1_draw_ff || out_free);
   assign req_tready    = !ctrl.busy && (!s1_valid_ff || out_free);
   assign accept        = req_tvalid && req_tready;
   assign draw_accept   = accept && req_tuser;
   assign reseed_accept = accept && !req_tuser;
   assign issue         = draw_accept || ctrl.step;

   assign back_addr = (wp_ff >= ADDR_W'(SHORT_LAG)) ? wp_ff - ADDR_W'(SHORT_LAG)
                                                   : wp_ff + ADDR_W'(LONG_LAG - SHORT_LAG);

   alf_seq #(
      .WARMUP_END (WARMUP_END)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .start (reseed_accept),
      .seed  (req_tdata),
      .ctrl  (ctrl)
   );

   // Entries never written since reset read as zero.
   assign sum = (va_ff ? rd_a : '0) + (vb_ff ? rd_b : '0);

   // The sequencer fills only while no step is in flight, so the ports never clash.
   assign ram_we    = s1_go || ctrl.wr_en;
   assign ram_waddr = s1_go ? s1_slot_ff : ctrl.wr_addr;
   assign ram_wdata = s1_go ? sum : ctrl.wr_data;

   alf_ram #(
      .WIDTH (WORD_W),
      .DEPTH (LONG_LAG)
   ) u_ring (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_en     (issue),
      .rd_addr_a (wp_ff),
      .rd_addr_b (back_addr),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_comb begin
      wp_in = wp_ff;
      if (ctrl.wp_load) begin
         wp_in = WARM_START;
      end else if (issue) begin
         wp_in = (wp_ff == LAST_SLOT) ? '0 : wp_ff + ADDR_W'(1);
      end
      valid_in = valid_ff;
      for (int i = 0; i < LONG_LAG; i++) begin
         if (ram_we && (ram_waddr == ADDR_W'(i))) begin
            valid_in[i] = 1'b1;
         end
      end
      s1_valid_in = issue ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      rsp_valid_in = (s1_go && s1_draw_ff) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         valid_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         valid_ff     <= valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (issue) begin
         s1_slot_ff <= wp_ff;
         s1_draw_ff <= draw_accept;
         va_ff      <= valid_ff[wp_ff];
         vb_ff      <= valid_ff[back_addr];
      end
      if (s1_go && s1_draw_ff) begin
         rsp_value_ff <= sum[31:1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_value_ff};

endmodule

### rtl/alf_checker.sv
// Port-level checker for the lagged Fibonacci generator, bound to the top level.
`include "additive_lagged_fibonacci_prng_unit_macros.svh"

module alf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic        draw_beat, reseed_beat, req_stall, rsp_stall;
   logic [32:0] req_word;

   assign draw_beat   = req_tvalid && req_tready && req_tuser;
   assign reseed_beat = req_tvalid && req_tready && !req_tuser;
   assign req_stall   = req_tvalid && !req_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign req_word    = {req_tuser, req_tdata};

   // A draw result passes from the draw's stage-one register into the result register behind rsp_tvalid.
   `ALF_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "result beat dropped")
   `ALF_ASSERT_NEXT(a_req_hold, req_stall, req_tvalid && $stable(req_word), "input beat changed")
   `ALF_ASSERT_NOW(a_rsp_pad, rsp_tvalid, !rsp_tdata[31], "padding bit of result set")
   `ALF_ASSERT_NEXT(a_reseed_busy, reseed_beat, !req_tready, "ready after reseed beat")
   `ALF_ASSERT_NOW(a_rsp_cause, $rose(rsp_tvalid), $past(draw_beat, 2), "result without draw")

endmodule

bind additive_lagged_fibonacci_prng_unit alf_checker u_alf_checker (.*);
